### hw/rtl/tssp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Timed stimulus sequence player package
// Shared constants, operation codes and the structs that travel between the
// configuration block, the sequencer, the shared arithmetic unit and the top.
// ============================================================================
package tssp_pkg;

    // Default depth of the entry table.
    localparam int TABLE_DEPTH_DEF = 256;

    // Configuration port geometry: six 32-bit registers at byte address 4*i.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes (paddr[4:2]).
    localparam logic [2:0] REG_START_INDEX   = 3'd0;
    localparam logic [2:0] REG_ELEMENT_COUNT = 3'd1;
    localparam logic [2:0] REG_LOOP_COUNT    = 3'd2;
    localparam logic [2:0] REG_JUMP_BACK     = 3'd3;
    localparam logic [2:0] REG_TRIGGER_MASK  = 3'd4;
    localparam logic [2:0] REG_SEQUENCE_ID   = 3'd5;

    // Config word upper half that marks a delay-only (dummy) entry.
    localparam logic [15:0] DUMMY_ID = 16'hFFFF;

    // Run status codes in the low half; the finished code is a whole word.
    localparam logic [15:0] RUN_STARTED  = 16'd1;
    localparam logic [15:0] RUN_LOOPING  = 16'd2;
    localparam logic [31:0] RUN_FINISHED = 32'd3;

    // Width of one table row: config word over delay.
    localparam int ENTRY_W = 64;

    // Input transaction modes.
    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_TICK  = 2'd3
    } mode_t;

    // Shared arithmetic unit operations.
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    // For a subtract, carry high means a >= b (no borrow).
    typedef struct packed {
        logic [31:0] sum;
        logic        carry;
    } alu_res_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_RED,
        ST_LOAD_WR,
        ST_START_RED,
        ST_JUMP_RED,
        ST_START_DUE,
        ST_TICK_CMP,
        ST_TICK_FIRE,
        ST_TICK_NEXT,
        ST_TICK_LOOP,
        ST_TICK_BACK,
        ST_TICK_RELOAD,
        ST_DONE
    } state_t;

    // Configuration register values.
    typedef struct packed {
        logic [7:0]  start_index;
        logic [15:0] element_count;
        logic [15:0] loop_count;
        logic [7:0]  jump_back;
        logic [15:0] trigger_mask;
        logic [15:0] sequence_id;
    } cfg_t;

    // One finished result.
    typedef struct packed {
        logic        fired;
        logic [7:0]  electrode_config_id;
        logic [31:0] trigger_word;
        logic [31:0] element_status;
        logic [31:0] run_status;
        logic        running;
    } res_t;

endpackage

### hw/rtl/tssp_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module tssp_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/tssp_alu.sv
`timescale 1ns / 1ps
// ============================================================================
// Shared 32-bit add / subtract unit
// Serves every time add, time compare, counter decrement and index reduction
// of the sequencer, one operation per cycle.
// ============================================================================
module tssp_alu (
    input  tssp_pkg::alu_req_t req,
    output tssp_pkg::alu_res_t res
);

    logic [32:0] sum_wide;
    logic [31:0] b_eff;
    logic        sub;

    // Subtraction is an add of the inverted operand with a carry in.
    always_comb begin
        sub      = (req.op == tssp_pkg::ALU_SUB);
        b_eff    = sub ? ~req.b : req.b;
        sum_wide = {1'b0, req.a} + {1'b0, b_eff} + {32'd0, sub};
        res.sum   = sum_wide[31:0];
        res.carry = sum_wide[32];
    end

endmodule

### hw/rtl/tssp_cfg.sv
`timescale 1ns / 1ps
// ============================================================================
// Configuration register block
// APB-style register file holding the six sequence setup registers.
// ============================================================================
module tssp_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tssp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tssp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tssp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output tssp_pkg::cfg_t                  cfg
);

    tssp_pkg::cfg_t cfg_reg;
    tssp_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register write decode.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                tssp_pkg::REG_START_INDEX:   cfg_next.start_index   = pwdata[7:0];
                tssp_pkg::REG_ELEMENT_COUNT: cfg_next.element_count = pwdata[15:0];
                tssp_pkg::REG_LOOP_COUNT:    cfg_next.loop_count    = pwdata[15:0];
                tssp_pkg::REG_JUMP_BACK:     cfg_next.jump_back     = pwdata[7:0];
                tssp_pkg::REG_TRIGGER_MASK:  cfg_next.trigger_mask  = pwdata[15:0];
                tssp_pkg::REG_SEQUENCE_ID:   cfg_next.sequence_id   = pwdata[15:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{start_index: 8'd0, element_count: 16'd0, loop_count: 16'd1,
                         jump_back: 8'd0, trigger_mask: 16'd0, sequence_id: 16'd0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read data mux.
    always_comb begin
        case (reg_idx)
            tssp_pkg::REG_START_INDEX:   prdata = {24'd0, cfg_reg.start_index};
            tssp_pkg::REG_ELEMENT_COUNT: prdata = {16'd0, cfg_reg.element_count};
            tssp_pkg::REG_LOOP_COUNT:    prdata = {16'd0, cfg_reg.loop_count};
            tssp_pkg::REG_JUMP_BACK:     prdata = {24'd0, cfg_reg.jump_back};
            tssp_pkg::REG_TRIGGER_MASK:  prdata = {16'd0, cfg_reg.trigger_mask};
            tssp_pkg::REG_SEQUENCE_ID:   prdata = {16'd0, cfg_reg.sequence_id};
            default:                     prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/tssp_seq.sv
`timescale 1ns / 1ps
// ============================================================================
// Sequence player sequencer
// Steps one input transaction through the table RAM and the shared
// arithmetic unit, holding the run state between transactions.
// ============================================================================
module tssp_seq #(
    parameter int  TABLE_DEPTH = tssp_pkg::TABLE_DEPTH_DEF,
    localparam int IW          = $clog2(TABLE_DEPTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic [31:0]                   s_time_now,
    input  logic [7:0]                    s_entry_index,
    input  logic [31:0]                   s_entry_word,
    input  logic [31:0]                   s_entry_delay,
    input  tssp_pkg::cfg_t                cfg,
    output tssp_pkg::alu_req_t            alu_req,
    input  tssp_pkg::alu_res_t            alu_res,
    output logic                          ram_we,
    output logic [IW-1:0]                 ram_waddr,
    output logic [tssp_pkg::ENTRY_W-1:0]  ram_wdata,
    output logic                          ram_re,
    output logic [IW-1:0]                 ram_raddr,
    input  logic [tssp_pkg::ENTRY_W-1:0]  ram_rdata,
    output tssp_pkg::res_t                res,
    output logic                          res_valid,
    input  logic                          res_ready
);

    localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
    localparam logic [IW-1:0] DEPTH_WRAP = IW'(TABLE_DEPTH);

    // Control and run state.
    tssp_pkg::state_t state_reg, state_next;
    logic [IW-1:0]    cur_idx_reg, cur_idx_next;
    logic [15:0]      entries_reg, entries_next;
    logic [15:0]      loops_reg, loops_next;
    logic [31:0]      due_reg, due_next;
    logic             enabled_reg, enabled_next;
    logic [31:0]      elem_status_reg, elem_status_next;
    logic [31:0]      run_status_reg, run_status_next;

    // Latched transaction and working registers.
    tssp_pkg::mode_t  mode_reg, mode_next;
    logic [31:0]      now_reg, now_next;
    logic [31:0]      word_in_reg, word_in_next;
    logic [31:0]      delay_in_reg, delay_in_next;
    logic [7:0]       acc_reg, acc_next;
    logic [IW-1:0]    jump_red_reg, jump_red_next;
    logic [7:0]       jump_raw_reg, jump_raw_next;
    logic [15:0]      mask_reg, mask_next;
    logic             fired_reg, fired_next;
    logic [7:0]       eid_reg, eid_next;
    logic [31:0]      trig_reg, trig_next;

    // Helpers.
    logic [IW-1:0]    inc_idx;
    logic [IW-1:0]    back_idx;
    logic [31:0]      mask_ext;
    logic [31:0]      mask_spread;
    logic [31:0]      trig_val;
    logic [31:0]      rd_word;
    logic [31:0]      rd_delay;

    assign rd_word  = ram_rdata[63:32];
    assign rd_delay = ram_rdata[31:0];

    // Next index with wrap at the table end, and the step back of a pass end.
    assign inc_idx  = (cur_idx_reg == LAST_IDX) ? '0 : cur_idx_reg + IW'(1);
    assign back_idx = alu_res.sum[IW-1:0] + (alu_res.carry ? '0 : DEPTH_WRAP);

    // Trigger word: mask spread by three lines, then mirrored to the upper half.
    assign mask_ext    = {16'd0, mask_reg};
    assign mask_spread = mask_ext | (mask_ext << 3);
    assign trig_val    = mask_spread | (mask_spread << 16);

    assign s_ready = (state_reg == tssp_pkg::ST_IDLE);

    // Sequencer: next state, shared unit operands and RAM control.
    always_comb begin
        state_next       = state_reg;
        cur_idx_next     = cur_idx_reg;
        entries_next     = entries_reg;
        loops_next       = loops_reg;
        due_next         = due_reg;
        enabled_next     = enabled_reg;
        elem_status_next = elem_status_reg;
        run_status_next  = run_status_reg;
        mode_next        = mode_reg;
        now_next         = now_reg;
        word_in_next     = word_in_reg;
        delay_in_next    = delay_in_reg;
        acc_next         = acc_reg;
        jump_red_next    = jump_red_reg;
        jump_raw_next    = jump_raw_reg;
        mask_next        = mask_reg;
        fired_next       = fired_reg;
        eid_next         = eid_reg;
        trig_next        = trig_reg;

        alu_req   = '{op: tssp_pkg::ALU_ADD, a: '0, b: '0};
        ram_we    = 1'b0;
        ram_waddr = IW'(acc_reg);
        ram_wdata = {word_in_reg, delay_in_reg};
        ram_re    = 1'b0;
        ram_raddr = cur_idx_reg;
        res_valid = 1'b0;

        case (state_reg)
            tssp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    mode_next     = tssp_pkg::mode_t'(s_mode);
                    now_next      = s_time_now;
                    word_in_next  = s_entry_word;
                    delay_in_next = s_entry_delay;
                    fired_next    = 1'b0;
                    eid_next      = '0;
                    trig_next     = '0;
                    case (tssp_pkg::mode_t'(s_mode))
                        tssp_pkg::MODE_LOAD: begin
                            acc_next   = s_entry_index;
                            state_next = tssp_pkg::ST_LOAD_RED;
                        end
                        tssp_pkg::MODE_START: begin
                            acc_next   = cfg.start_index;
                            state_next = tssp_pkg::ST_START_RED;
                        end
                        tssp_pkg::MODE_STOP: begin
                            enabled_next = 1'b0;
                            state_next   = tssp_pkg::ST_DONE;
                        end
                        tssp_pkg::MODE_TICK: begin
                            state_next = enabled_reg ? tssp_pkg::ST_TICK_CMP
                                                     : tssp_pkg::ST_DONE;
                        end
                        default: state_next = tssp_pkg::ST_DONE;
                    endcase
                end
            end

            // Reduce the load index below the table depth by repeated subtraction.
            tssp_pkg::ST_LOAD_RED: begin
                alu_req = '{op: tssp_pkg::ALU_SUB, a: {24'd0, acc_reg}, b: DEPTH_W};
                if (alu_res.carry) begin
                    acc_next = alu_res.sum[7:0];
                end else begin
                    state_next = tssp_pkg::ST_LOAD_WR;
                end
            end

            tssp_pkg::ST_LOAD_WR: begin
                ram_we     = 1'b1;
                state_next = tssp_pkg::ST_DONE;
            end

            // Reduce the start index, then the jump-back distance.
            tssp_pkg::ST_START_RED: begin
                alu_req = '{op: tssp_pkg::ALU_SUB, a: {24'd0, acc_reg}, b: DEPTH_W};
                if (alu_res.carry) begin
                    acc_next = alu_res.sum[7:0];
                end else begin
                    cur_idx_next = IW'(acc_reg);
                    acc_next     = cfg.jump_back;
                    state_next   = tssp_pkg::ST_JUMP_RED;
                end
            end

            tssp_pkg::ST_JUMP_RED: begin
                alu_req = '{op: tssp_pkg::ALU_SUB, a: {24'd0, acc_reg}, b: DEPTH_W};
                if (alu_res.carry) begin
                    acc_next = alu_res.sum[7:0];
                end else begin
                    jump_red_next = IW'(acc_reg);
                    ram_re        = 1'b1;
                    ram_raddr     = cur_idx_reg;
                    state_next    = tssp_pkg::ST_START_DUE;
                end
            end

            // First due time and the run state copy.
            tssp_pkg::ST_START_DUE: begin
                alu_req = '{op: tssp_pkg::ALU_ADD, a: now_reg, b: rd_delay};
                due_next      = alu_res.sum;
                entries_next  = cfg.element_count;
                loops_next    = cfg.loop_count;
                jump_raw_next = cfg.jump_back;
                mask_next     = cfg.trigger_mask;
                if (cfg.element_count != 16'd0) begin
                    run_status_next = {cfg.sequence_id, tssp_pkg::RUN_STARTED};
                    enabled_next    = 1'b1;
                end
                state_next = tssp_pkg::ST_DONE;
            end

            // Unsigned time compare: fire when now >= due.
            tssp_pkg::ST_TICK_CMP: begin
                alu_req = '{op: tssp_pkg::ALU_SUB, a: now_reg, b: due_reg};
                if (alu_res.carry) begin
                    ram_re     = 1'b1;
                    ram_raddr  = cur_idx_reg;
                    state_next = tssp_pkg::ST_TICK_FIRE;
                end else begin
                    state_next = tssp_pkg::ST_DONE;
                end
            end

            // Fire the current entry unless it is a dummy, and count it off.
            tssp_pkg::ST_TICK_FIRE: begin
                if (rd_word[31:16] != tssp_pkg::DUMMY_ID) begin
                    fired_next       = 1'b1;
                    eid_next         = rd_word[23:16];
                    trig_next        = trig_val;
                    elem_status_next = {8'd0, rd_word[31:24], 16'(cur_idx_reg)};
                end
                alu_req = '{op: tssp_pkg::ALU_SUB, a: {16'd0, entries_reg}, b: 32'd1};
                entries_next = alu_res.sum[15:0];
                if (alu_res.sum[15:0] != 16'd0) begin
                    cur_idx_next = inc_idx;
                    ram_re       = 1'b1;
                    ram_raddr    = inc_idx;
                    state_next   = tssp_pkg::ST_TICK_NEXT;
                end else begin
                    state_next = tssp_pkg::ST_TICK_LOOP;
                end
            end

            tssp_pkg::ST_TICK_NEXT: begin
                alu_req    = '{op: tssp_pkg::ALU_ADD, a: due_reg, b: rd_delay};
                due_next   = alu_res.sum;
                state_next = tssp_pkg::ST_DONE;
            end

            // End of a pass: another pass or the finish.
            tssp_pkg::ST_TICK_LOOP: begin
                alu_req = '{op: tssp_pkg::ALU_SUB, a: {16'd0, loops_reg}, b: 32'd1};
                loops_next = alu_res.sum[15:0];
                if (alu_res.sum[15:0] != 16'd0) begin
                    state_next = tssp_pkg::ST_TICK_BACK;
                end else begin
                    run_status_next = tssp_pkg::RUN_FINISHED;
                    enabled_next    = 1'b0;
                    state_next      = tssp_pkg::ST_DONE;
                end
            end

            // Step back over the looped tail, wrapping below zero.
            tssp_pkg::ST_TICK_BACK: begin
                alu_req = '{op: tssp_pkg::ALU_SUB, a: 32'(cur_idx_reg), b: 32'(jump_red_reg)};
                cur_idx_next    = back_idx;
                entries_next    = 16'(jump_raw_reg) + 16'd1;
                run_status_next = {loops_reg, tssp_pkg::RUN_LOOPING};
                ram_re          = 1'b1;
                ram_raddr       = back_idx;
                state_next      = tssp_pkg::ST_TICK_RELOAD;
            end

            tssp_pkg::ST_TICK_RELOAD: begin
                alu_req    = '{op: tssp_pkg::ALU_ADD, a: now_reg, b: rd_delay};
                due_next   = alu_res.sum;
                state_next = tssp_pkg::ST_DONE;
            end

            // Hand the result to the output stage.
            tssp_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = tssp_pkg::ST_IDLE;
                end
            end

            default: state_next = tssp_pkg::ST_IDLE;
        endcase
    end

    assign res = '{fired: fired_reg, electrode_config_id: eid_reg, trigger_word: trig_reg,
                   element_status: elem_status_reg, run_status: run_status_reg,
                   running: enabled_reg};

    // State and run registers are cleared by reset; working registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= tssp_pkg::ST_IDLE;
            cur_idx_reg     <= '0;
            entries_reg     <= '0;
            loops_reg       <= '0;
            due_reg         <= '0;
            enabled_reg     <= 1'b0;
            elem_status_reg <= '0;
            run_status_reg  <= '0;
        end else begin
            state_reg       <= state_next;
            cur_idx_reg     <= cur_idx_next;
            entries_reg     <= entries_next;
            loops_reg       <= loops_next;
            due_reg         <= due_next;
            enabled_reg     <= enabled_next;
            elem_status_reg <= elem_status_next;
            run_status_reg  <= run_status_next;
        end
        mode_reg     <= mode_next;
        now_reg      <= now_next;
        word_in_reg  <= word_in_next;
        delay_in_reg <= delay_in_next;
        acc_reg      <= acc_next;
        jump_red_reg <= jump_red_next;
        jump_raw_reg <= jump_raw_next;
        mask_reg     <= mask_next;
        fired_reg    <= fired_next;
        eid_reg      <= eid_next;
        trig_reg     <= trig_next;
    end

endmodule

### hw/rtl/timed_stimulus_sequence_player_top.sv
`timescale 1ns / 1ps
// Each input transaction (load, start, stop or time tick) is stepped through
// the sequencer and the input is not ready meanwhile; exactly one result
// transaction follows each input. The sequencer steps one add or compare at a
// time through the single shared 32-bit adder and reads the entry table
// through its one registered read port. For a table smaller than 256 entries,
// each index taken from an 8-bit field (load index, start index, jump back)
// is reduced by repeated subtraction. A finished result waits in an output
// register, so the next input transaction is taken while it is still
// pending. The table has no reset: entries read before they are loaded
// return undefined data.
// ============================================================================
// Timed stimulus sequence player
// Plays a loaded table of (config word, delay) entries against a time base,
// firing trigger words when entries fall due, with looping of a table tail.
// ============================================================================
module timed_stimulus_sequence_player_top #(
    parameter int TABLE_DEPTH = tssp_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_mode,
    input  logic [31:0]                     s_time_now,
    input  logic [7:0]                      s_entry_index,
    input  logic [31:0]                     s_entry_word,
    input  logic [31:0]                     s_entry_delay,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_fired,
    output logic [7:0]                      m_electrode_config_id,
    output logic [31:0]                     m_trigger_word,
    output logic [31:0]                     m_element_status,
    output logic [31:0]                     m_run_status,
    output logic                            m_running,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tssp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tssp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tssp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int IW = $clog2(TABLE_DEPTH);

    tssp_pkg::cfg_t                 cfg;
    tssp_pkg::alu_req_t             alu_req;
    tssp_pkg::alu_res_t             alu_res;
    tssp_pkg::res_t                 res;
    logic                           res_valid;
    logic                           res_ready;
    logic                           ram_we;
    logic [IW-1:0]                  ram_waddr;
    logic [tssp_pkg::ENTRY_W-1:0]   ram_wdata;
    logic                           ram_re;
    logic [IW-1:0]                  ram_raddr;
    logic [tssp_pkg::ENTRY_W-1:0]   ram_rdata;

    logic           m_valid_reg, m_valid_next;
    tssp_pkg::res_t m_res_reg, m_res_next;

    // Configuration registers.
    tssp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Entry table: config word in the upper half, delay in the lower half.
    tssp_ram #(
        .WIDTH (tssp_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared adder / comparator.
    tssp_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // Sequencer.
    tssp_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_time_now    (s_time_now),
        .s_entry_index (s_entry_index),
        .s_entry_word  (s_entry_word),
        .s_entry_delay (s_entry_delay),
        .cfg           (cfg),
        .alu_req       (alu_req),
        .alu_res       (alu_res),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .res           (res),
        .res_valid     (res_valid),
        .res_ready     (res_ready)
    );

    // Output register: takes a new result when empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_valid               = m_valid_reg;
    assign m_fired               = m_res_reg.fired;
    assign m_electrode_config_id = m_res_reg.electrode_config_id;
    assign m_trigger_word        = m_res_reg.trigger_word;
    assign m_element_status      = m_res_reg.element_status;
    assign m_run_status          = m_res_reg.run_status;
    assign m_running             = m_res_reg.running;

`ifndef NO_ASSERTIONS
    // An accepted transaction leaves the idle state, so input ready is low in the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready stayed high after an accepted transaction");

    // A finished run is never reported as still running.
    a_finished_not_running: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_run_status == tssp_pkg::RUN_FINISHED) |-> !m_running)
        else $error("run status finished while sequence still running");

    // A fired entry with an all-ones tag cannot also carry an all-ones electrode id.
    a_fire_not_dummy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fired && (m_element_status[23:16] == 8'hFF)
        |-> (m_electrode_config_id != 8'hFF))
        else $error("dummy entry reported as fired");

    // A pending result stays offered until the receiver takes it.
    a_result_not_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("pending result transaction dropped");
`endif

endmodule

### test/timed_stimulus_sequence_player_top_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Timed stimulus sequence player testbench
// Loads the whole entry table, then plays directed and random sequences
// through the valid/ready input channel. The configuration is written over
// the APB-style port while the block is idle. Every result transaction is
// checked field by field against a cycle-free predictor of the player.
// ============================================================================
module timed_stimulus_sequence_player_top_test;
    import tssp_pkg::*;

    localparam int DEPTH = 256;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = MODE_STOP;
    logic [31:0] s_time_now = '0;
    logic [7:0]  s_entry_index = '0;
    logic [31:0] s_entry_word = '0;
    logic [31:0] s_entry_delay = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_fired;
    logic [7:0]  m_electrode_config_id;
    logic [31:0] m_trigger_word;
    logic [31:0] m_element_status;
    logic [31:0] m_run_status;
    logic        m_running;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic        pready;

    // Test control.
    int   send_idle_pct = 19;
    int   recv_idle_pct = 76;
    int   items_sent = 0;
    int   failures = 0;
    logic [31:0] tick_time = '0;
    res_t pending_results[$];

    // Predictor state: table, playback state and register copy.
    logic [31:0] tbl_word [DEPTH];
    logic [31:0] tbl_delay [DEPTH];
    logic [7:0]  play_index = '0;
    logic [15:0] play_left = '0;
    logic [15:0] play_loops = '0;
    logic [31:0] play_due = '0;
    logic        play_on = 1'b0;
    logic [31:0] elem_status = '0;
    logic [31:0] run_status = '0;
    logic [15:0] play_mask = '0;
    logic [7:0]  play_jump = '0;
    cfg_t        cfg_shadow = '{start_index: 8'd0, element_count: 16'd0,
                                loop_count: 16'd1, jump_back: 8'd0,
                                trigger_mask: 16'd0, sequence_id: 16'd0};

    timed_stimulus_sequence_player_top #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_mode                (s_mode),
        .s_time_now            (s_time_now),
        .s_entry_index         (s_entry_index),
        .s_entry_word          (s_entry_word),
        .s_entry_delay         (s_entry_delay),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_fired               (m_fired),
        .m_electrode_config_id (m_electrode_config_id),
        .m_trigger_word        (m_trigger_word),
        .m_element_status      (m_element_status),
        .m_run_status          (m_run_status),
        .m_running             (m_running),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready)
    );

    // Clock with a 20 ns period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Computes the result of one input transaction and advances the player.
    function automatic res_t predict_player(mode_t mode, logic [31:0] now,
                                            logic [7:0] idx, logic [31:0] word,
                                            logic [31:0] delay);
        res_t        r;
        logic [31:0] w;
        logic [31:0] m;
        r = '0;
        case (mode)
            MODE_LOAD: begin
                tbl_word[idx] = word;
                tbl_delay[idx] = delay;
            end
            MODE_START: begin
                play_index = cfg_shadow.start_index;
                play_left = cfg_shadow.element_count;
                play_loops = cfg_shadow.loop_count;
                play_jump = cfg_shadow.jump_back;
                play_mask = cfg_shadow.trigger_mask;
                play_due = now + tbl_delay[play_index];
                // A zero count loads the state but does not start a run.
                if (cfg_shadow.element_count != 16'd0) begin
                    run_status = {cfg_shadow.sequence_id, RUN_STARTED};
                    play_on = 1'b1;
                end
            end
            MODE_STOP: begin
                play_on = 1'b0;
            end
            default: begin
                if (play_on && now >= play_due) begin
                    w = tbl_word[play_index];
                    // Dummy entries only contribute their delay.
                    if (w[31:16] != DUMMY_ID) begin
                        m = {16'h0, play_mask} | ({16'h0, play_mask} << 3);
                        m = m | (m << 16);
                        elem_status = {8'h0, w[31:24], 8'h0, play_index};
                        r.fired = 1'b1;
                        r.electrode_config_id = w[23:16];
                        r.trigger_word = m;
                    end
                    play_left = play_left - 16'd1;
                    if (play_left != 16'd0) begin
                        play_index = play_index + 8'd1;
                        play_due = play_due + tbl_delay[play_index];
                    end else begin
                        play_loops = play_loops - 16'd1;
                        if (play_loops != 16'd0) begin
                            play_index = play_index - play_jump;
                            play_left = {8'h0, play_jump} + 16'd1;
                            play_due = now + tbl_delay[play_index];
                            run_status = {play_loops, RUN_LOOPING};
                        end else begin
                            run_status = RUN_FINISHED;
                            play_on = 1'b0;
                        end
                    end
                end
            end
        endcase
        r.element_status = elem_status;
        r.run_status = run_status;
        r.running = play_on;
        return r;
    endfunction

    // Value a register read is expected to return.
    function automatic logic [31:0] reg_readback(logic [2:0] reg_idx);
        case (reg_idx)
            REG_START_INDEX:   return {24'h0, cfg_shadow.start_index};
            REG_ELEMENT_COUNT: return {16'h0, cfg_shadow.element_count};
            REG_LOOP_COUNT:    return {16'h0, cfg_shadow.loop_count};
            REG_JUMP_BACK:     return {24'h0, cfg_shadow.jump_back};
            REG_TRIGGER_MASK:  return {16'h0, cfg_shadow.trigger_mask};
            default:           return {16'h0, cfg_shadow.sequence_id};
        endcase
    endfunction

    // Result side: random back-pressure and comparison with the oldest expectation.
    task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, exp_val, act_val);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        res_t exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no pending expectation");
                failures++;
            end else begin
                exp_res = pending_results.pop_front();
                compare_field("fired", 32'(exp_res.fired), 32'(m_fired));
                compare_field("electrode_config_id", 32'(exp_res.electrode_config_id),
                              32'(m_electrode_config_id));
                compare_field("trigger_word", exp_res.trigger_word, m_trigger_word);
                compare_field("element_status", exp_res.element_status, m_element_status);
                compare_field("run_status", exp_res.run_status, m_run_status);
                compare_field("running", 32'(exp_res.running), 32'(m_running));
            end
        end
    end

    // Sends one input transaction, with a random idle gap in front of it.
    task automatic send_item(mode_t mode, logic [31:0] now, logic [7:0] idx,
                             logic [31:0] word, logic [31:0] delay);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_time_now <= now;
        s_entry_index <= idx;
        s_entry_word <= word;
        s_entry_delay <= delay;
        pending_results.push_back(predict_player(mode, now, idx, word, delay));
        items_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Start, stop or tick with random content in the unused fields.
    task automatic send_control(mode_t mode, logic [31:0] now);
        send_item(mode, now, 8'($urandom), $urandom, $urandom);
    endtask

    // Random table entry: some dummies, mostly short delays.
    task automatic send_random_load(logic [7:0] idx);
        logic [31:0] word;
        logic [31:0] delay;
        word = $urandom;
        if ($urandom_range(99) < 20) word[31:16] = DUMMY_ID;
        delay = ($urandom_range(99) < 10) ? $urandom : 32'($urandom_range(0, 4));
        send_item(MODE_LOAD, $urandom, idx, word, delay);
    endtask

    // Holds the sender off until every expected result has been taken.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] reg_idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (reg_idx)
            REG_START_INDEX:   cfg_shadow.start_index = value[7:0];
            REG_ELEMENT_COUNT: cfg_shadow.element_count = value[15:0];
            REG_LOOP_COUNT:    cfg_shadow.loop_count = value[15:0];
            REG_JUMP_BACK:     cfg_shadow.jump_back = value[7:0];
            REG_TRIGGER_MASK:  cfg_shadow.trigger_mask = value[15:0];
            default:           cfg_shadow.sequence_id = value[15:0];
        endcase
        @(posedge aclk);
    endtask

    task automatic apb_read_check(logic [2:0] reg_idx);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {reg_idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        compare_field("prdata", reg_readback(reg_idx), prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Rewrites all six registers once the block has gone idle.
    task automatic set_config(logic [7:0] si, logic [15:0] ec, logic [15:0] lc,
                              logic [7:0] jb, logic [15:0] tm, logic [15:0] sid);
        wait_drained();
        apb_write(REG_START_INDEX, {24'h0, si});
        apb_write(REG_ELEMENT_COUNT, {16'h0, ec});
        apb_write(REG_LOOP_COUNT, {16'h0, lc});
        apb_write(REG_JUMP_BACK, {24'h0, jb});
        apb_write(REG_TRIGGER_MASK, {16'h0, tm});
        apb_write(REG_SEQUENCE_ID, {16'h0, sid});
    endtask

    task automatic read_all_regs();
        apb_read_check(REG_START_INDEX);
        apb_read_check(REG_ELEMENT_COUNT);
        apb_read_check(REG_LOOP_COUNT);
        apb_read_check(REG_JUMP_BACK);
        apb_read_check(REG_TRIGGER_MASK);
        apb_read_check(REG_SEQUENCE_ID);
    endtask

    // Reset values, then all ones and all zeros, each read back.
    task automatic test_config_port();
        read_all_regs();
        set_config(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        read_all_regs();
        set_config(8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000);
        read_all_regs();
    endtask

    // Ticks and a stop while nothing runs; none of these touch the table.
    task automatic test_stopped_items();
        send_control(MODE_TICK, 32'h0000_0000);
        send_control(MODE_TICK, 32'hFFFF_FFFF);
        send_control(MODE_STOP, 32'hFFFF_FFFF);
    endtask

    // Every entry is loaded before anything can read the table.
    task automatic test_table_fill();
        for (int i = 0; i < DEPTH; i++) begin
            send_random_load(8'(i));
        end
    endtask

    task automatic test_directed_runs();
        // Entries around the index wrap, including a dummy.
        send_item(MODE_LOAD, 32'h0, 8'd255, 32'hA53C_1234, 32'h0);
        send_item(MODE_LOAD, 32'h0, 8'd0, 32'h0000_0000, 32'h0);
        send_item(MODE_LOAD, 32'h0, 8'd1, 32'hFFFF_0000, 32'h0);
        send_item(MODE_LOAD, 32'hFFFF_FFFF, 8'd2, 32'hFFFE_FFFF, 32'h20);

        // A start with a zero element count does not enable playback.
        set_config(8'd0, 16'd0, 16'd1, 8'd0, 16'h0000, 16'h0000);
        send_control(MODE_START, 32'd5);
        send_control(MODE_TICK, 32'd100);

        // Two passes with a jump back of one, the first across the index wrap.
        set_config(8'd255, 16'd3, 16'd2, 8'd1, 16'hFFFF, 16'hFFFF);
        send_control(MODE_START, 32'd0);
        repeat (6) send_control(MODE_TICK, 32'd0);

        // Due time that wraps past 2^32, and the unsigned compare.
        set_config(8'd2, 16'd1, 16'd1, 8'd0, 16'h0001, 16'h8000);
        send_control(MODE_START, 32'hFFFF_FFF0);
        send_control(MODE_TICK, 32'hFFFF_FFF8);
        send_control(MODE_START, 32'hFFFF_FFF0);
        send_control(MODE_TICK, 32'h0000_000F);
        send_control(MODE_TICK, 32'h0000_0010);

        // Zero loop count wraps, and a full jump back steps forward one entry.
        set_config(8'd0, 16'd1, 16'd0, 8'd255, 16'h8000, 16'h0000);
        send_control(MODE_START, 32'd0);
        send_control(MODE_TICK, 32'd0);
        send_control(MODE_TICK, 32'd0);
        send_control(MODE_TICK, 32'd0);
        send_control(MODE_TICK, 32'h20);
        send_control(MODE_STOP, 32'h20);
        send_control(MODE_TICK, 32'h40);
    endtask

    // One well-formed run with random settings, sprinkled with noise.
    task automatic run_random_sequence();
        int          r;
        int          n;
        logic [15:0] ec;
        logic [15:0] lc;
        logic [7:0]  jb;
        r = $urandom_range(99);
        ec = (r < 5) ? 16'd0 : (r < 10) ? 16'hFFFF : (r < 15) ? 16'($urandom)
            : 16'($urandom_range(1, 8));
        r = $urandom_range(99);
        lc = (r < 5) ? 16'd0 : (r < 10) ? 16'hFFFF : (r < 15) ? 16'($urandom)
            : 16'($urandom_range(1, 4));
        jb = ($urandom_range(99) < 10) ? 8'($urandom) : 8'($urandom_range(0, 7));
        set_config(8'($urandom), ec, lc, jb, 16'($urandom), 16'($urandom));
        tick_time = $urandom;
        send_control(MODE_START, tick_time);
        n = $urandom_range(8, 30);
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 80) begin
                tick_time += ($urandom_range(99) < 3) ? $urandom
                    : 32'($urandom_range(0, 3));
                send_control(MODE_TICK, tick_time);
            end else if (r < 88) begin
                send_random_load(8'($urandom));
            end else if (r < 94) begin
                send_control(MODE_STOP, tick_time);
            end else begin
                send_control(MODE_START, tick_time);
            end
        end
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, int count);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = items_sent + count;
        while (items_sent < target) run_random_sequence();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_config_port();
        test_stopped_items();
        test_table_fill();
        test_directed_runs();
        test_random_traffic(19, 76, 190);
        test_random_traffic(76, 19, 190);
        test_random_traffic(0, 0, 190);
        wait_drained();
        repeat (20) @(posedge aclk);
        if (failures == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
